### rtl/lpac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpac_pkg: shared types and constants of the largest piece after cuts unit
// Widths, register indexes, controller states and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package lpac_pkg;
  localparam int MaxExtent = 4096;
  localparam int PosW      = $clog2(MaxExtent + 1);
  localparam int CntW      = 13;
  localparam int AreaW     = 25;
  localparam int CfgW      = 13;
  localparam int IdxW      = 1;

  localparam logic [IdxW-1:0] RegSheetWidth  = 1'b0;
  localparam logic [IdxW-1:0] RegSheetHeight = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_CHECK_W, ST_SCAN_LO, ST_SCAN_HI, ST_DEC, ST_DEC_W,
    ST_INC_A, ST_INC_A_W, ST_INC_B, ST_INC_B_W, ST_FIND, ST_MUL, ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;    // write zeros at sweep address (count 1 at the extent), advance
    logic clr_start;   // reset sweep address
    logic load_item;   // capture input item
    logic lo_start;
    logic lo_step;
    logic hi_start;
    logic hi_step;
    logic set_map;     // mark cut, read count[len]
    logic dec_wr;      // write count[len]-1
    logic rd_a;
    logic wr_a;
    logic rd_b;
    logic wr_b;
    logic find_start;
    logic find_step;
    logic big_ld;      // take the found length as largest gap
    logic mul;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic invalid;     // out of range
    logic map_hit;     // probe already cut
    logic lo_done;
    logic hi_done;
    logic need_find;
    logic find_done;
  } stat_t;
endpackage
`default_nettype wire

### rtl/lpac_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpac_datapath: cut maps, length count memories, gap registers, multiplier
// One map and one count memory per axis, one read and one write each per cycle.
// ----------------------------------------------------------------------------
module lpac_datapath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire lpac_pkg::cmd_t       cmd_i,
  output lpac_pkg::stat_t           stat_o,
  input  wire                       cfg_we_i,
  input  wire [lpac_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire [lpac_pkg::CfgW-1:0]  cfg_data_i,
  input  wire                       in_axis_i,
  input  wire [lpac_pkg::PosW-1:0]  in_pos_i,
  output logic [lpac_pkg::AreaW-1:0] area_o
);
  import lpac_pkg::*;

  logic                 map_h [MaxExtent+1];
  logic                 map_v [MaxExtent+1];
  logic [CntW-1:0]      cnt_h [MaxExtent+1];
  logic [CntW-1:0]      cnt_v [MaxExtent+1];

  logic [PosW-1:0] ext_w_q, ext_h_q, big_h_q, big_v_q;
  logic [PosW-1:0] clr_q, pos_q, lo_q, hi_q, len_q, fl_q;
  logic            axis_q, mrd_q, nf_q;
  logic [CntW-1:0] crd_q;
  logic [AreaW-1:0] area_q;

  logic [PosW-1:0] ext, big, probe_addr, wa;
  logic [CntW-1:0] wd;
  logic            mwe, mwd, cwe, ax;
  logic [PosW-1:0] cfg_val;

  // during a clearing pass the axis comes from the sweep, else from the item
  assign ax  = cmd_i.clr_step ? in_axis_i : axis_q;
  assign ext = ax ? ext_w_q : ext_h_q;
  assign big = axis_q ? big_v_q : big_h_q;
  assign cfg_val = (cfg_data_i == '0) ? PosW'(1) :
                   ((cfg_data_i > CfgW'(MaxExtent)) ? PosW'(MaxExtent) : PosW'(cfg_data_i));

  // extents and largest gaps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_w_q <= PosW'(MaxExtent);
      ext_h_q <= PosW'(MaxExtent);
      big_h_q <= PosW'(MaxExtent);
      big_v_q <= PosW'(MaxExtent);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegSheetWidth) begin
        ext_w_q <= cfg_val; big_v_q <= cfg_val; big_h_q <= ext_h_q;
      end else begin
        ext_h_q <= cfg_val; big_h_q <= cfg_val; big_v_q <= ext_w_q;
      end
    end else if (cmd_i.big_ld) begin
      if (axis_q) big_v_q <= fl_q; else big_h_q <= fl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cfg_we_i || cmd_i.clr_start) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + PosW'(1);
  end
  assign stat_o.clr_done = (clr_q == PosW'(MaxExtent));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      axis_q <= in_axis_i;
      pos_q  <= in_pos_i;
    end
    if (cmd_i.lo_start) lo_q <= pos_q - PosW'(1);
    else if (cmd_i.lo_step) lo_q <= lo_q - PosW'(1);
    if (cmd_i.hi_start) hi_q <= pos_q + PosW'(1);
    else if (cmd_i.hi_step) hi_q <= hi_q + PosW'(1);
    if (cmd_i.set_map) len_q <= hi_q - lo_q;
    // the split piece was the last one of the largest length
    if (cmd_i.dec_wr) nf_q <= (len_q == big) && (crd_q <= CntW'(1));
    if (cmd_i.find_start) fl_q <= len_q;
    else if (cmd_i.find_step) fl_q <= fl_q - PosW'(1);
    if (cmd_i.mul) area_q <= AreaW'(big_h_q) * AreaW'(big_v_q);
  end

  // map probe address: item position, then scan pointers
  always_comb begin
    probe_addr = pos_q;
    if (cmd_i.lo_start) probe_addr = pos_q - PosW'(1);
    else if (cmd_i.lo_step) probe_addr = lo_q - PosW'(1);
    else if (cmd_i.hi_start) probe_addr = pos_q + PosW'(1);
    else if (cmd_i.hi_step) probe_addr = hi_q + PosW'(1);
  end

  // memory write port selection
  always_comb begin
    mwe = 1'b0; mwd = 1'b0; cwe = 1'b0; wa = pos_q; wd = '0;
    if (cmd_i.clr_step) begin
      mwe = 1'b1; cwe = 1'b1; wa = clr_q;
      wd = (clr_q == ext) ? CntW'(1) : '0;
    end else if (cmd_i.set_map) begin
      mwe = 1'b1; mwd = 1'b1;
    end else if (cmd_i.dec_wr) begin
      cwe = (crd_q != '0); wa = len_q; wd = crd_q - CntW'(1);
    end else if (cmd_i.wr_a) begin
      cwe = 1'b1; wa = pos_q - lo_q; wd = crd_q + CntW'(1);
    end else if (cmd_i.wr_b) begin
      cwe = 1'b1; wa = hi_q - pos_q; wd = crd_q + CntW'(1);
    end
  end

  // count read address; hold count[len] while idle between set_map and dec_wr
  logic [PosW-1:0] ca;
  always_comb begin
    ca = len_q;
    if (cmd_i.set_map) ca = hi_q - lo_q;
    else if (cmd_i.rd_a) ca = pos_q - lo_q;
    else if (cmd_i.rd_b) ca = hi_q - pos_q;
    else if (cmd_i.find_start) ca = len_q;
    else if (cmd_i.find_step) ca = fl_q - PosW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      if (ax) map_v[wa] <= mwd; else map_h[wa] <= mwd;
    end
    if (cwe) begin
      if (ax) cnt_v[wa] <= wd; else cnt_h[wa] <= wd;
    end
    mrd_q <= axis_q ? map_v[probe_addr] : map_h[probe_addr];
    crd_q <= axis_q ? cnt_v[ca] : cnt_h[ca];
  end

  assign stat_o.invalid   = (pos_q == '0) || (pos_q >= ext);
  assign stat_o.map_hit   = mrd_q;
  assign stat_o.lo_done   = (lo_q == '0) || mrd_q;
  assign stat_o.hi_done   = (hi_q >= ext) || mrd_q;
  assign stat_o.need_find = nf_q;
  assign stat_o.find_done = (crd_q != '0) || (fl_q <= PosW'(1));
  assign area_o = area_q;
endmodule
`default_nettype wire

### rtl/lpac_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpac_ctrl: sequencer of the largest piece after cuts unit
// Runs clearing sweeps, the neighbor scans, count updates and the output.
// ----------------------------------------------------------------------------
module lpac_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic                 sweep_axis_o,
  output lpac_pkg::cmd_t       cmd_o,
  input  wire lpac_pkg::stat_t stat_i
);
  import lpac_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d, sw_q, sw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; ov_q <= 1'b0; sw_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; sw_q <= sw_d;
    end
  end

  always_comb begin
    state_d = state_q; ov_d = ov_q; sw_d = sw_q; cmd_o = '0;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        // the last address is written in the cycle that restarts the sweep
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          cmd_o.clr_start = 1'b1;
          if (sw_q) begin sw_d = 1'b0; state_d = ST_IDLE; end
          else sw_d = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          cmd_o.load_item = 1'b1; state_d = ST_CHECK;
        end
      end
      ST_CHECK: state_d = ST_CHECK_W;
      ST_CHECK_W: begin
        if (stat_i.invalid || stat_i.map_hit) state_d = ST_MUL;
        else begin cmd_o.lo_start = 1'b1; state_d = ST_SCAN_LO; end
      end
      ST_SCAN_LO: begin
        if (stat_i.lo_done) begin cmd_o.hi_start = 1'b1; state_d = ST_SCAN_HI; end
        else cmd_o.lo_step = 1'b1;
      end
      ST_SCAN_HI: begin
        if (stat_i.hi_done) begin cmd_o.set_map = 1'b1; state_d = ST_DEC; end
        else cmd_o.hi_step = 1'b1;
      end
      ST_DEC: state_d = ST_DEC_W;
      ST_DEC_W: begin cmd_o.dec_wr = 1'b1; state_d = ST_INC_A; end
      ST_INC_A: begin cmd_o.rd_a = 1'b1; state_d = ST_INC_A_W; end
      ST_INC_A_W: begin cmd_o.wr_a = 1'b1; state_d = ST_INC_B; end
      ST_INC_B: begin cmd_o.rd_b = 1'b1; state_d = ST_INC_B_W; end
      ST_INC_B_W: begin
        cmd_o.wr_b = 1'b1; cmd_o.find_start = 1'b1;
        state_d = stat_i.need_find ? ST_FIND : ST_MUL;
      end
      ST_FIND: begin
        // first cycle after find_start checks count[len]; walk down if empty
        if (stat_i.find_done) begin cmd_o.big_ld = 1'b1; state_d = ST_MUL; end
        else cmd_o.find_step = 1'b1;
      end
      ST_MUL: begin cmd_o.mul = 1'b1; state_d = ST_OUT; end
      ST_OUT: begin ov_d = 1'b1; state_d = ST_IDLE; end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = ST_CLEAR; sw_d = 1'b0; cmd_o = '0;
    end
  end

  assign out_valid_o  = ov_q;
  assign sweep_axis_o = sw_q;
endmodule
`default_nettype wire

### rtl/largest_piece_after_cuts_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// largest_piece_after_cuts_unit: area of the largest piece of a cut sheet
// Tracks cuts on two axes and reports the largest gap product per cut.
// ----------------------------------------------------------------------------
// One item (a cut) yields one result item, the largest area. The cut is
// checked, then positions are scanned on each side of it to find its
// neighbor cuts (at least one each), the length counts are updated and,
// when the last piece of the largest gap is split, lengths are stepped
// down one by one to find the new largest gap: all set by the single read
// port of each axis memory. A cut at an edge, beyond it or on an existing
// cut skips the scans and updates. After reset and after each register
// write a clearing pass over all MAX_EXTENT + 1 addresses runs (one axis
// after the other) while no item is taken. A finished result is held in
// the output register until taken, and no new item is taken before that.
module largest_piece_after_cuts_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire [0:0]   cfg_idx_i,
  input  wire [12:0]  cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [15:0]  s_axis_tdata,   // [0] command, [13:1] cut_position
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // [24:0] largest_area
);
  import lpac_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  sweep_axis, busy_axis;
  logic [AreaW-1:0] area;

  lpac_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .sweep_axis_o (sweep_axis), .cmd_o (cmd), .stat_i (stat)
  );

  // during a clearing pass the axis select follows the sweep
  assign busy_axis = cmd.clr_step ? sweep_axis : s_axis_tdata[0];

  lpac_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .stat_o (stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_axis_i (busy_axis), .in_pos_i (s_axis_tdata[PosW:1]),
    .area_o (area)
  );

  assign m_axis_tdata = {7'd0, area};
endmodule
`default_nettype wire
